// ===== rtl/cfr_pkg.sv =====
// Shared types, codes and frame constants for the CO2 sensor frame reader.
// No dependencies; every other file in rtl/ imports this package.

package cfr_pkg;

    // Operation codes of an input beat
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_RX    = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_CAL   = 2'd3;

    // Result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Reading status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TIMEOUT   = 3'd1;
    localparam logic [2:0] ST_BAD_HDR   = 3'd2;
    localparam logic [2:0] ST_BAD_CSUM  = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_AUTO_CAL = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_PPM_LIM  = 2'd2;

    // Frame bytes
    localparam logic [7:0] FRM_START    = 8'hFF;
    localparam logic [7:0] FRM_ADDR     = 8'h01;
    localparam logic [7:0] CMD_READ     = 8'h86;
    localparam logic [7:0] CMD_CAL      = 8'h79;
    localparam logic [7:0] CAL_ON       = 8'hA0;
    localparam logic [7:0] CAL_OFF      = 8'h00;
    localparam int         FRAME_LEN    = 9;
    localparam logic [3:0] LAST_IDX     = 4'(FRAME_LEN - 1);

    // Register reset values
    localparam logic [9:0]  TIMEOUT_RST = 10'd200;
    localparam logic [15:0] PPM_LIM_RST = 16'd5000;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [15:0] ppm;
        logic [2:0]  status;
    } t_out_item;

    // Request from the reply tracker to the frame sequencer
    typedef struct packed {
        logic       start;
        logic [7:0] cmd;
        logic [7:0] arg;
    } t_frm_req;

    // One transmit byte offered by the frame sequencer
    typedef struct packed {
        logic       valid;
        logic [7:0] tx_byte;
        logic       last;
    } t_frm_beat;

    // Finished-reading result from the reply tracker
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_trk_res;

endpackage

// ===== rtl/cfr_tracker.sv =====
// Reply tracker: request decode, reply byte checks, tick timeout.
// Depends on cfr_pkg.

module cfr_tracker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  cfr_pkg::t_in_item i_item,
    input  logic              i_auto_cal,
    input  logic [9:0]        i_timeout,
    input  logic [15:0]       i_ppm_limit,
    output cfr_pkg::t_frm_req o_req,
    output cfr_pkg::t_trk_res o_res
);
    import cfr_pkg::*;

    logic       r_awaiting, n_awaiting;
    logic [3:0] r_count,    n_count;
    logic [9:0] r_elapsed,  n_elapsed;
    logic [7:0] r_sum,      n_sum;
    logic       r_hdr_ok,   n_hdr_ok;
    logic [7:0] r_val_hi,   n_val_hi;
    logic [7:0] r_val_lo,   n_val_lo;

    logic [15:0] value;
    logic [7:0]  expect_cs;
    logic [2:0]  status;

    assign value     = {r_val_hi, r_val_lo};
    assign expect_cs = 8'h00 - r_sum;

    // Fault priority: header, checksum, range
    always_comb begin
        priority if (!r_hdr_ok) begin
            status = ST_BAD_HDR;
        end else if (expect_cs != i_item.rx_byte) begin
            status = ST_BAD_CSUM;
        end else if (value > i_ppm_limit) begin
            status = ST_RANGE;
        end else begin
            status = ST_OK;
        end
    end

    // Next state and outputs for one accepted beat
    always_comb begin
        n_awaiting = r_awaiting;
        n_count    = r_count;
        n_elapsed  = r_elapsed;
        n_sum      = r_sum;
        n_hdr_ok   = r_hdr_ok;
        n_val_hi   = r_val_hi;
        n_val_lo   = r_val_lo;
        o_req      = '0;
        o_res      = '0;
        if (i_accept) begin
            unique case (i_item.operation)
                OP_START: begin
                    if (!r_awaiting) begin
                        n_awaiting = 1'b1;
                        n_count    = '0;
                        n_elapsed  = '0;
                        n_sum      = '0;
                        n_hdr_ok   = 1'b1;
                        n_val_hi   = '0;
                        n_val_lo   = '0;
                        o_req.start = 1'b1;
                        o_req.cmd   = CMD_READ;
                        o_req.arg   = CAL_OFF;
                    end
                end
                OP_CAL: begin
                    o_req.start = 1'b1;
                    o_req.cmd   = CMD_CAL;
                    o_req.arg   = i_auto_cal ? CAL_ON : CAL_OFF;
                end
                OP_TICK: begin
                    if (r_awaiting) begin
                        if (r_elapsed >= i_timeout) begin
                            n_awaiting = 1'b0;
                            n_count    = '0;
                            n_elapsed  = '0;
                            n_sum      = '0;
                            n_hdr_ok   = 1'b1;
                            n_val_hi   = '0;
                            n_val_lo   = '0;
                            o_res.valid       = 1'b1;
                            o_res.item.kind   = KIND_DONE;
                            o_res.item.status = ST_TIMEOUT;
                        end else begin
                            n_elapsed = r_elapsed + 10'd1;
                        end
                    end
                end
                OP_RX: begin
                    if (r_awaiting) begin
                        if (r_count == 4'd0) begin
                            if (i_item.rx_byte != FRM_START) n_hdr_ok = 1'b0;
                            n_count = r_count + 4'd1;
                        end else if (r_count < LAST_IDX) begin
                            if (r_count == 4'd1 && i_item.rx_byte != CMD_READ) begin
                                n_hdr_ok = 1'b0;
                            end
                            if (r_count == 4'd2) n_val_hi = i_item.rx_byte;
                            if (r_count == 4'd3) n_val_lo = i_item.rx_byte;
                            n_sum   = r_sum + i_item.rx_byte;
                            n_count = r_count + 4'd1;
                        end else begin
                            n_awaiting = 1'b0;
                            n_count    = '0;
                            n_elapsed  = '0;
                            n_sum      = '0;
                            n_hdr_ok   = 1'b1;
                            n_val_hi   = '0;
                            n_val_lo   = '0;
                            o_res.valid       = 1'b1;
                            o_res.item.kind   = KIND_DONE;
                            o_res.item.status = status;
                            o_res.item.ppm    = (status == ST_OK) ? value : 16'd0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_count    <= '0;
            r_elapsed  <= '0;
            r_sum      <= '0;
            r_hdr_ok   <= 1'b1;
            r_val_hi   <= '0;
            r_val_lo   <= '0;
        end else begin
            r_awaiting <= n_awaiting;
            r_count    <= n_count;
            r_elapsed  <= n_elapsed;
            r_sum      <= n_sum;
            r_hdr_ok   <= n_hdr_ok;
            r_val_hi   <= n_val_hi;
            r_val_lo   <= n_val_lo;
        end
    end

endmodule

// ===== rtl/cfr_framer.sv =====
// Command frame sequencer: offers the nine bytes of a command, one per beat.
// Depends on cfr_pkg.

module cfr_framer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfr_pkg::t_frm_req  i_req,
    input  logic               i_advance,
    output cfr_pkg::t_frm_beat o_beat
);
    import cfr_pkg::*;

    logic       r_active, n_active;
    logic [3:0] r_idx,    n_idx;
    logic [7:0] r_cmd,    n_cmd;
    logic [7:0] r_arg,    n_arg;
    logic [7:0] csum;
    logic [7:0] byte_sel;

    // Two's complement of bytes 1..7 (only address, command and argument are non-zero)
    assign csum = 8'h00 - (FRM_ADDR + r_cmd + r_arg);

    always_comb begin
        unique case (r_idx)
            4'd0:    byte_sel = FRM_START;
            4'd1:    byte_sel = FRM_ADDR;
            4'd2:    byte_sel = r_cmd;
            4'd3:    byte_sel = r_arg;
            LAST_IDX: byte_sel = csum;
            default: byte_sel = 8'h00;
        endcase
    end

    assign o_beat.valid   = r_active;
    assign o_beat.tx_byte = byte_sel;
    assign o_beat.last    = (r_idx == LAST_IDX);

    // Index advances on each beat taken by the output register
    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        n_cmd    = r_cmd;
        n_arg    = r_arg;
        if (i_req.start) begin
            n_active = 1'b1;
            n_idx    = '0;
            n_cmd    = i_req.cmd;
            n_arg    = i_req.arg;
        end else if (r_active && i_advance) begin
            if (r_idx == LAST_IDX) begin
                n_active = 1'b0;
                n_idx    = '0;
            end else begin
                n_idx = r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_arg <= n_arg;
    end

endmodule

// ===== rtl/co2_sensor_frame_reader.sv =====
// CO2 sensor frame reader top level: config registers, output register.
// Depends on cfr_pkg, cfr_tracker, cfr_framer.
// A finished-reading result is registered in the cycle after its beat is accepted;
// the first frame byte passes the framer and output registers, then one byte per
// cycle unless stalled. Throughput: one beat per cycle while the output is free,
// but a command request holds the input for its nine beats. Reset is synchronous.

module co2_sensor_frame_reader (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  cfr_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output cfr_pkg::t_out_item o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import cfr_pkg::*;

    logic        r_auto_cal;
    logic [9:0]  r_timeout;
    logic [15:0] r_ppm_lim;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic      out_free;
    logic      in_accept;
    t_frm_req  req;
    t_trk_res  res;
    t_frm_beat beat;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = beat.valid || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_cal <= 1'b0;
            r_timeout  <= TIMEOUT_RST;
            r_ppm_lim  <= PPM_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_AUTO_CAL: r_auto_cal <= i_cfg_data[0];
                REG_TIMEOUT:  r_timeout  <= i_cfg_data[9:0];
                REG_PPM_LIM:  r_ppm_lim  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cfr_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in_data),
        .i_auto_cal  (r_auto_cal),
        .i_timeout   (r_timeout),
        .i_ppm_limit (r_ppm_lim),
        .o_req       (req),
        .o_res       (res)
    );

    cfr_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_advance (out_free),
        .o_beat    (beat)
    );

    // Output register: frame bytes or a finished-reading result
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (out_free) begin
            if (beat.valid) begin
                n_out_valid     = 1'b1;
                n_out           = '0;
                n_out.kind      = KIND_TX;
                n_out.tx_byte   = beat.tx_byte;
                n_out.last      = beat.last;
            end else if (res.valid) begin
                n_out_valid = 1'b1;
                n_out       = res.item;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
